// ===== rtl/dual_spectrum_peak_bin_finder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_SPECTRUM_PEAK_BIN_FINDER_ASSERT_SVH
`define DUAL_SPECTRUM_PEAK_BIN_FINDER_ASSERT_SVH

// cond must never hold
`define DSPBF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante in this cycle implies cons in the next
`define DSPBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dspbf_pkg.sv =====
// ----------------------------------------------------------------------------
// dspbf_pkg
// Shared types and constants of the dual spectrum peak bin finder.
// ----------------------------------------------------------------------------
package dspbf_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int DEFAULT_WINDOW_LEN = 1024;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/dspbf_front.sv =====
// ----------------------------------------------------------------------------
// dspbf_front
// Magnitude pipeline: abs and square, sum, then one root bit per stage.
// ----------------------------------------------------------------------------
module dspbf_front #(
  parameter int SB = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [SB-1:0]  in_real_a,
  input  logic signed [SB-1:0]  in_imag_a,
  input  logic signed [SB-1:0]  in_real_b,
  input  logic signed [SB-1:0]  in_imag_b,
  input  dspbf_pkg::q_stat_t    q_stat_i,
  output logic                  push_o,
  output logic [2*SB-1:0]       push_data_o
);

  localparam int XW = 2 * SB;
  localparam int RW = SB + 2;

  function automatic logic [SB-1:0] abs_f(input logic [SB-1:0] v);
    return v[SB-1] ? (~v + 1'b1) : v;
  endfunction

  logic          adv;
  logic          vsq_r;
  logic [SB:0]   vld_r;
  logic [XW-1:0] sq_nxt   [2][2];
  logic [XW-1:0] sq_r     [2][2];
  logic [XW-1:0] x_r      [2][SB+1];
  logic [RW-1:0] rem_r    [2][SB+1];
  logic [SB-1:0] root_r   [2][SB+1];
  logic [RW-1:0] rem_sh   [2][SB];
  logic [RW-1:0] tst      [2][SB];
  logic          ge       [2][SB];
  logic [RW-1:0] rem_nxt  [2][SB];
  logic [SB-1:0] root_nxt [2][SB];

  assign adv         = !vld_r[SB] || !q_stat_i.full;
  assign in_ready    = adv;
  assign push_o      = vld_r[SB] && !q_stat_i.full;
  assign push_data_o = {root_r[0][SB], root_r[1][SB]};

  always_comb begin
    sq_nxt[0][0] = XW'(abs_f(in_real_a)) * XW'(abs_f(in_real_a));
    sq_nxt[0][1] = XW'(abs_f(in_imag_a)) * XW'(abs_f(in_imag_a));
    sq_nxt[1][0] = XW'(abs_f(in_real_b)) * XW'(abs_f(in_real_b));
    sq_nxt[1][1] = XW'(abs_f(in_imag_b)) * XW'(abs_f(in_imag_b));
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      for (int s = 0; s < SB; s++) begin
        rem_sh[c][s]   = {rem_r[c][s][RW-3:0], x_r[c][s][XW-1 -: 2]};
        tst[c][s]      = {root_r[c][s], 2'b01};
        ge[c][s]       = rem_sh[c][s] >= tst[c][s];
        rem_nxt[c][s]  = ge[c][s] ? (rem_sh[c][s] - tst[c][s]) : rem_sh[c][s];
        root_nxt[c][s] = {root_r[c][s][SB-2:0], ge[c][s]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsq_r <= 1'b0;
      vld_r <= '0;
    end else if (adv) begin
      vsq_r       <= in_valid;
      vld_r[0]    <= vsq_r;
      vld_r[SB:1] <= vld_r[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 2; c++) begin
        sq_r[c][0]   <= sq_nxt[c][0];
        sq_r[c][1]   <= sq_nxt[c][1];
        x_r[c][0]    <= sq_r[c][0] + sq_r[c][1];
        rem_r[c][0]  <= '0;
        root_r[c][0] <= '0;
        for (int s = 0; s < SB; s++) begin
          x_r[c][s+1]    <= x_r[c][s] << 2;
          rem_r[c][s+1]  <= rem_nxt[c][s];
          root_r[c][s+1] <= root_nxt[c][s];
        end
      end
    end
  end

endmodule

// ===== rtl/dspbf_queue.sv =====
// ----------------------------------------------------------------------------
// dspbf_queue
// Short FIFO of magnitude pairs between the front pipeline and the tracker.
// ----------------------------------------------------------------------------
`include "dual_spectrum_peak_bin_finder_assert.svh"

module dspbf_queue #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  logic [WIDTH-1:0]   push_data_i,
  input  logic               pop_i,
  output logic [WIDTH-1:0]   pop_data_o,
  output dspbf_pkg::q_stat_t stat_o
);

  localparam int QD = dspbf_pkg::QUEUE_DEPTH;
  localparam int PW = dspbf_pkg::QPTR_W;
  localparam int CW = dspbf_pkg::QCNT_W;

  logic [WIDTH-1:0] entry_r [QD];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign stat_o.full  = cnt_r == CW'(QD);
  assign stat_o.empty = cnt_r == '0;
  assign pop_data_o   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_i ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      entry_r[wr_ptr_r] <= push_data_i;
    end
  end

  `DSPBF_ASSERT_NEVER(a_q_no_overflow, push_i && cnt_r == CW'(QD), "queue push while full")
  `DSPBF_ASSERT_NEVER(a_q_no_underflow, pop_i && cnt_r == '0, "queue pop while empty")
  `DSPBF_ASSERT_NEXT(a_q_fill, push_i && !pop_i, cnt_r == $past(cnt_r) + 1'b1, "queue count lost a push")

endmodule

// ===== rtl/dspbf_back.sv =====
// ----------------------------------------------------------------------------
// dspbf_back
// Peak trackers for both spectra, window counter, result register.
// ----------------------------------------------------------------------------
module dspbf_back #(
  parameter int MAX_BINS = 1024,
  parameter int SB       = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [$clog2(MAX_BINS):0]    cfg_wr_data,
  input  dspbf_pkg::q_stat_t           q_stat_i,
  input  logic [2*SB-1:0]              pop_data_i,
  output logic                         pop_o,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [$clog2(MAX_BINS)-1:0]  out_peak_index_a,
  output logic [$clog2(MAX_BINS)-1:0]  out_peak_index_b
);

  localparam int IDX_W   = $clog2(MAX_BINS);
  localparam int LEN_W   = IDX_W + 1;
  localparam int RST_LEN = (MAX_BINS < dspbf_pkg::DEFAULT_WINDOW_LEN) ?
                           MAX_BINS : dspbf_pkg::DEFAULT_WINDOW_LEN;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] bin_cnt_r, bin_cnt_nxt;
  logic [SB-1:0]    best_mag_a_r, best_mag_a_nxt;
  logic [SB-1:0]    best_mag_b_r, best_mag_b_nxt;
  logic [IDX_W-1:0] best_bin_a_r, best_bin_a_nxt;
  logic [IDX_W-1:0] best_bin_b_r, best_bin_b_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] peak_a_r, peak_a_nxt;
  logic [IDX_W-1:0] peak_b_r, peak_b_nxt;
  logic [SB-1:0]    mag_a, mag_b;
  logic [LEN_W-1:0] cnt_inc;
  logic             upd_a, upd_b, last;
  logic [IDX_W-1:0] bin_a, bin_b;

  assign mag_a            = pop_data_i[2*SB-1:SB];
  assign mag_b            = pop_data_i[SB-1:0];
  assign pop_o            = !q_stat_i.empty && (!out_valid_r || out_ready);
  assign out_valid        = out_valid_r;
  assign out_peak_index_a = peak_a_r;
  assign out_peak_index_b = peak_b_r;

  always_comb begin
    upd_a   = mag_a > best_mag_a_r;
    upd_b   = mag_b > best_mag_b_r;
    bin_a   = upd_a ? bin_cnt_r : best_bin_a_r;
    bin_b   = upd_b ? bin_cnt_r : best_bin_b_r;
    cnt_inc = {1'b0, bin_cnt_r} + 1'b1;
    last    = cnt_inc >= len_r;
  end

  // window length write, clamped to 1..MAX_BINS
  always_comb begin
    len_nxt = len_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        len_nxt = LEN_W'(1);
      end else if (cfg_wr_data > LEN_W'(MAX_BINS)) begin
        len_nxt = LEN_W'(MAX_BINS);
      end else begin
        len_nxt = cfg_wr_data;
      end
    end
  end

  always_comb begin
    bin_cnt_nxt    = bin_cnt_r;
    best_mag_a_nxt = best_mag_a_r;
    best_mag_b_nxt = best_mag_b_r;
    best_bin_a_nxt = best_bin_a_r;
    best_bin_b_nxt = best_bin_b_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    peak_a_nxt     = peak_a_r;
    peak_b_nxt     = peak_b_r;
    if (pop_o) begin
      if (last) begin
        out_valid_nxt  = 1'b1;
        peak_a_nxt     = bin_a;
        peak_b_nxt     = bin_b;
        bin_cnt_nxt    = '0;
        best_mag_a_nxt = '0;
        best_mag_b_nxt = '0;
        best_bin_a_nxt = '0;
        best_bin_b_nxt = '0;
      end else begin
        bin_cnt_nxt    = cnt_inc[IDX_W-1:0];
        best_mag_a_nxt = upd_a ? mag_a : best_mag_a_r;
        best_mag_b_nxt = upd_b ? mag_b : best_mag_b_r;
        best_bin_a_nxt = bin_a;
        best_bin_b_nxt = bin_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= LEN_W'(RST_LEN);
      bin_cnt_r    <= '0;
      best_mag_a_r <= '0;
      best_mag_b_r <= '0;
      best_bin_a_r <= '0;
      best_bin_b_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      len_r        <= len_nxt;
      bin_cnt_r    <= bin_cnt_nxt;
      best_mag_a_r <= best_mag_a_nxt;
      best_mag_b_r <= best_mag_b_nxt;
      best_bin_a_r <= best_bin_a_nxt;
      best_bin_b_r <= best_bin_b_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    peak_a_r <= peak_a_nxt;
    peak_b_r <= peak_b_nxt;
  end

endmodule

// ===== rtl/dual_spectrum_peak_bin_finder.sv =====
// ----------------------------------------------------------------------------
// dual_spectrum_peak_bin_finder
// Peak bin index of two complex spectra per window of bins.
// ----------------------------------------------------------------------------
// Accepts one bin of each spectrum per clock and sustains that rate as long
// as results are taken. Each bin's floored magnitude comes out of a
// SAMPLE_BITS+2 stage pipeline (abs and square, sum, one root bit per stage)
// into a four-entry queue; the tracker takes one queued pair per cycle while
// no unread result holds it. A window's last bin passes the pipeline and the
// queue to the tracker, and its result is held in an output register; while it
// waits, the queue and then the pipeline fill before in_ready drops.
// window_length is clamped to 1..MAX_BINS; ties keep the earliest bin and an
// all-zero window reports 0.
// ----------------------------------------------------------------------------
module dual_spectrum_peak_bin_finder #(
  parameter int MAX_BINS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [$clog2(MAX_BINS):0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_real_a,
  input  logic signed [SAMPLE_BITS-1:0] in_imag_a,
  input  logic signed [SAMPLE_BITS-1:0] in_real_b,
  input  logic signed [SAMPLE_BITS-1:0] in_imag_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [$clog2(MAX_BINS)-1:0]   out_peak_index_a,
  output logic [$clog2(MAX_BINS)-1:0]   out_peak_index_b
);

  dspbf_pkg::q_stat_t       q_stat;
  logic                     q_push, q_pop;
  logic [2*SAMPLE_BITS-1:0] q_wdata, q_rdata;

  dspbf_front #(
    .SB (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_real_a   (in_real_a),
    .in_imag_a   (in_imag_a),
    .in_real_b   (in_real_b),
    .in_imag_b   (in_imag_b),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .push_data_o (q_wdata)
  );

  dspbf_queue #(
    .WIDTH (2 * SAMPLE_BITS)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .stat_o      (q_stat)
  );

  dspbf_back #(
    .MAX_BINS (MAX_BINS),
    .SB       (SAMPLE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .q_stat_i         (q_stat),
    .pop_data_i       (q_rdata),
    .pop_o            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_peak_index_a (out_peak_index_a),
    .out_peak_index_b (out_peak_index_b)
  );

endmodule
